FILE: sv/hpt_pkg.sv
// Shared constants and the arctangent table for the helix pivot transform.
// No dependencies; the CORDICs, the transform unit and the bench import this package.
package hpt_pkg;

   // Fixed-point constants
   localparam longint ONE_Q30     = 64'sd1073741824;
   localparam longint GAIN_Q30    = 64'sd652032874;
   localparam longint TWO_PI_Q28  = 64'sd1686629713;
   localparam longint LIM33       = 64'sd8589934592;

   // Curvature constant register
   localparam int          ALPHA_W     = 31;
   localparam logic [30:0] ALPHA_RESET = 31'd21860456;

   // Radius divider: dividend is alpha shifted up by 16
   localparam int DIV_BITS = ALPHA_W + 16;

   // atan(2^-k) as a fraction of a full turn
   function automatic logic [31:0] atan_turn(input logic [4:0] k);
      logic [31:0] a;
      unique case (k)
         5'd0:  a = 32'h20000000;
         5'd1:  a = 32'h12E4051E;
         5'd2:  a = 32'h09FB385B;
         5'd3:  a = 32'h051111D4;
         5'd4:  a = 32'h028B0D43;
         5'd5:  a = 32'h0145D7E1;
         5'd6:  a = 32'h00A2F61E;
         5'd7:  a = 32'h00517C55;
         5'd8:  a = 32'h0028BE53;
         5'd9:  a = 32'h00145F2F;
         5'd10: a = 32'h000A2F98;
         5'd11: a = 32'h000517CC;
         5'd12: a = 32'h00028BE6;
         5'd13: a = 32'h000145F3;
         5'd14: a = 32'h0000A2FA;
         5'd15: a = 32'h0000517D;
         5'd16: a = 32'h000028BE;
         5'd17: a = 32'h0000145F;
         5'd18: a = 32'h00000A30;
         5'd19: a = 32'h00000518;
         5'd20: a = 32'h0000028C;
         5'd21: a = 32'h00000146;
         5'd22: a = 32'h000000A3;
         5'd23: a = 32'h00000051;
         5'd24: a = 32'h00000029;
         5'd25: a = 32'h00000014;
         5'd26: a = 32'h0000000A;
         5'd27: a = 32'h00000005;
         5'd28: a = 32'h00000003;
         5'd29: a = 32'h00000001;
         5'd30: a = 32'h00000001;
         default: a = 32'h00000000;
      endcase
      return a;
   endfunction

endpackage

FILE: sv/hpt_req_if.sv
// Request channel of the helix pivot transform: valid/ready plus one helix beat.
// No dependencies.
interface hpt_req_if;
   logic               valid;
   logic               ready;
   logic signed [31:0] ref_x;
   logic signed [31:0] ref_y;
   logic signed [31:0] ref_z;
   logic signed [31:0] transverse_offset;
   logic        [31:0] azimuth;
   logic signed [31:0] curvature;
   logic signed [31:0] longitudinal_offset;
   logic signed [31:0] dip_tangent;
   logic signed [31:0] target_x;
   logic signed [31:0] target_y;
   logic signed [31:0] target_z;

   modport source (
      output valid, ref_x, ref_y, ref_z, transverse_offset, azimuth, curvature,
             longitudinal_offset, dip_tangent, target_x, target_y, target_z,
      input  ready
   );
   modport sink (
      input  valid, ref_x, ref_y, ref_z, transverse_offset, azimuth, curvature,
             longitudinal_offset, dip_tangent, target_x, target_y, target_z,
      output ready
   );
endinterface

FILE: sv/hpt_rsp_if.sv
// Response channel of the helix pivot transform: valid/ready plus one result beat.
// No dependencies.
interface hpt_rsp_if;
   logic               valid;
   logic               ready;
   logic signed [31:0] out_transverse_offset;
   logic        [31:0] out_azimuth;
   logic signed [31:0] out_longitudinal_offset;
   logic               radius_saturated;
   logic               direction_degenerate;

   modport source (
      output valid, out_transverse_offset, out_azimuth, out_longitudinal_offset,
             radius_saturated, direction_degenerate,
      input  ready
   );
   modport sink (
      input  valid, out_transverse_offset, out_azimuth, out_longitudinal_offset,
             radius_saturated, direction_degenerate,
      output ready
   );
endinterface

FILE: sv/hpt_cordic_rot.sv
// Pipelined rotation CORDIC: turn-fraction angle to clamped Q2.30 cosine and sine.
// Depends on hpt_pkg (gain constant, arctangent table).
module hpt_cordic_rot import hpt_pkg::*; #(
   parameter int STAGES = 24
) (
   input  logic               clock,
   input  logic               enable,
   input  logic        [31:0] angle,
   output logic signed [31:0] cos_out,
   output logic signed [31:0] sin_out
);

   typedef struct packed {
      logic signed [33:0] x;
      logic signed [33:0] y;
      logic signed [33:0] z;
      logic               flip;
   } rot_type;

   rot_type            stg_in [STAGES+1];
   rot_type            stg_ff [STAGES+1];
   logic signed [31:0] cos_in, sin_in, cos_ff, sin_ff;

   // Fold the angle into the right half plane, then iterate
   always_comb begin
      logic [31:0]        sum;
      logic [31:0]        t;
      logic signed [33:0] dx, dy;
      sum          = angle + 32'h4000_0000;
      stg_in[0].flip = sum[31];
      t            = sum[31] ? (angle + 32'h8000_0000) : angle;
      stg_in[0].z  = 34'($signed(t));
      stg_in[0].x  = 34'(GAIN_Q30);
      stg_in[0].y  = '0;
      for (int i = 0; i < STAGES; i++) begin
         dx = stg_ff[i].y >>> i;
         dy = stg_ff[i].x >>> i;
         stg_in[i+1].flip = stg_ff[i].flip;
         if (stg_ff[i].z >= 0) begin
            stg_in[i+1].x = stg_ff[i].x - dx;
            stg_in[i+1].y = stg_ff[i].y + dy;
            stg_in[i+1].z = stg_ff[i].z - $signed({2'b00, atan_turn(5'(i))});
         end else begin
            stg_in[i+1].x = stg_ff[i].x + dx;
            stg_in[i+1].y = stg_ff[i].y - dy;
            stg_in[i+1].z = stg_ff[i].z + $signed({2'b00, atan_turn(5'(i))});
         end
      end
   end

   // Undo the fold and clamp to +-1.0
   always_comb begin
      logic signed [33:0] xo, yo;
      xo = stg_ff[STAGES].flip ? -stg_ff[STAGES].x : stg_ff[STAGES].x;
      yo = stg_ff[STAGES].flip ? -stg_ff[STAGES].y : stg_ff[STAGES].y;
      if (xo > ONE_Q30)       cos_in = 32'(ONE_Q30);
      else if (xo < -ONE_Q30) cos_in = 32'(-ONE_Q30);
      else                    cos_in = 32'(xo);
      if (yo > ONE_Q30)       sin_in = 32'(ONE_Q30);
      else if (yo < -ONE_Q30) sin_in = 32'(-ONE_Q30);
      else                    sin_in = 32'(yo);
   end

   // Advance all stages together
   always_ff @(posedge clock) begin
      if (enable) begin
         for (int i = 0; i <= STAGES; i++) stg_ff[i] <= stg_in[i];
         cos_ff <= cos_in;
         sin_ff <= sin_in;
      end
   end

   assign cos_out = cos_ff;
   assign sin_out = sin_ff;

endmodule

FILE: sv/hpt_cordic_vec.sv
// Pipelined vectoring CORDIC: angle of a nonzero (x, y) as a turn fraction.
// Depends on hpt_pkg (arctangent table).
module hpt_cordic_vec import hpt_pkg::*; #(
   parameter int STAGES = 24
) (
   input  logic               clock,
   input  logic               enable,
   input  logic signed [35:0] x_in,
   input  logic signed [35:0] y_in,
   output logic        [31:0] phi
);

   localparam int NORM_BIT = 40;
   localparam int NORM_N   = 6;
   localparam int LAST     = STAGES + NORM_N + 1;

   typedef struct packed {
      logic signed [45:0] x;
      logic signed [45:0] y;
      logic        [31:0] z;
   } vec_type;

   vec_type vs_in [LAST+1];
   vec_type vs_ff [LAST+1];

   always_comb begin
      logic signed [45:0] xe, ye, ay, m, lim, dx, dy;
      // Mirror into the right half plane
      xe = 46'(x_in);
      ye = 46'(y_in);
      if (xe < 0) begin
         vs_in[0].x = -xe;
         vs_in[0].y = -ye;
         vs_in[0].z = 32'h8000_0000;
      end else begin
         vs_in[0].x = xe;
         vs_in[0].y = ye;
         vs_in[0].z = '0;
      end
      // Normalize: shift by 32, 16, ... 1 while the magnitude stays below 2^40
      for (int j = 0; j < NORM_N; j++) begin
         ay  = (vs_ff[j].y < 0) ? -vs_ff[j].y : vs_ff[j].y;
         m   = (vs_ff[j].x > ay) ? vs_ff[j].x : ay;
         lim = 46'sd1 <<< (NORM_BIT - (32 >> j));
         vs_in[j+1] = vs_ff[j];
         if (m < lim) begin
            vs_in[j+1].x = vs_ff[j].x <<< (32 >> j);
            vs_in[j+1].y = vs_ff[j].y <<< (32 >> j);
         end
      end
      // One last doubling lifts the magnitude to 2^40 or above
      ay  = (vs_ff[NORM_N].y < 0) ? -vs_ff[NORM_N].y : vs_ff[NORM_N].y;
      m   = (vs_ff[NORM_N].x > ay) ? vs_ff[NORM_N].x : ay;
      lim = 46'sd1 <<< NORM_BIT;
      vs_in[NORM_N+1] = vs_ff[NORM_N];
      if (m < lim) begin
         vs_in[NORM_N+1].x = vs_ff[NORM_N].x <<< 1;
         vs_in[NORM_N+1].y = vs_ff[NORM_N].y <<< 1;
      end
      // Drive y toward zero, accumulating the angle
      for (int i = 0; i < STAGES; i++) begin
         dx = vs_ff[NORM_N+1+i].y >>> i;
         dy = vs_ff[NORM_N+1+i].x >>> i;
         if (vs_ff[NORM_N+1+i].y < 0) begin
            vs_in[NORM_N+2+i].x = vs_ff[NORM_N+1+i].x - dx;
            vs_in[NORM_N+2+i].y = vs_ff[NORM_N+1+i].y + dy;
            vs_in[NORM_N+2+i].z = vs_ff[NORM_N+1+i].z - atan_turn(5'(i));
         end else begin
            vs_in[NORM_N+2+i].x = vs_ff[NORM_N+1+i].x + dx;
            vs_in[NORM_N+2+i].y = vs_ff[NORM_N+1+i].y - dy;
            vs_in[NORM_N+2+i].z = vs_ff[NORM_N+1+i].z + atan_turn(5'(i));
         end
      end
   end

   // Advance all stages together
   always_ff @(posedge clock) begin
      if (enable) begin
         for (int i = 0; i <= LAST; i++) vs_ff[i] <= vs_in[i];
      end
   end

   assign phi = vs_ff[LAST].z;

endmodule

FILE: sv/helix_pivot_transform_unit.sv
// Helix pivot transform: re-expresses a track helix about a new reference point.
// Throughput one beat per cycle while the response is not stalled; divider and CORDICs are fully pipelined.
// A stalled response freezes the whole pipeline; nothing is dropped.
// Reset clears the valid chain and loads the curvature constant; no clearing pass.
module helix_pivot_transform_unit import hpt_pkg::*; #(
   parameter int CORDIC_STAGES = 24
) (
   input  logic                 clock,
   input  logic                 reset,
   hpt_req_if.sink              req_ch,
   hpt_rsp_if.source            rsp_ch,
   input  logic                 csr_wr_en,
   input  logic [ALPHA_W-1:0]   csr_wr_data
);

   localparam int ROT_LAT = CORDIC_STAGES + 2;
   localparam int VEC_LAT = CORDIC_STAGES + 8;
   localparam int VLD_N   = 59 + VEC_LAT + ROT_LAT;
   localparam int ROT_TAP = DIV_BITS - ROT_LAT;

   typedef struct packed {
      logic signed [31:0] rx;
      logic signed [31:0] ry;
      logic signed [31:0] rz;
      logic signed [31:0] dr;
      logic        [31:0] phi0;
      logic signed [31:0] kap;
      logic signed [31:0] dz;
      logic signed [31:0] tl;
      logic signed [31:0] tx;
      logic signed [31:0] ty;
      logic signed [31:0] tz;
      logic signed [31:0] r;
      logic               rsat;
      logic signed [31:0] c0;
      logic signed [31:0] s0;
      logic signed [32:0] rdr;
      logic signed [63:0] mdc;
      logic signed [63:0] mds;
      logic signed [63:0] mrt;
      logic signed [63:0] mxc;
      logic signed [63:0] mys;
      logic signed [35:0] pxb;
      logic signed [35:0] pyb;
      logic signed [34:0] rt;
      logic signed [33:0] zb;
      logic signed [35:0] dx;
      logic signed [35:0] dy;
      logic               deg;
      logic        [31:0] phi;
      logic signed [31:0] cs;
      logic signed [31:0] sn;
      logic signed [32:0] phid;
      logic signed [32:0] dcs;
      logic signed [32:0] dsn;
      logic signed [63:0] mrc;
      logic signed [63:0] mrs;
      logic signed [63:0] mph;
      logic signed [35:0] px;
      logic signed [35:0] py;
      logic signed [31:0] ph;
      logic signed [63:0] mpc;
      logic signed [63:0] mps;
      logic signed [63:0] mrp;
   } trk_type;

   typedef struct packed {
      logic [31:0]          rem;
      logic [DIV_BITS-1:0]  quo;
   } div_type;

   typedef struct packed {
      logic signed [31:0] drp;
      logic        [31:0] phi;
      logic signed [31:0] dzp;
      logic               rsat;
      logic               deg;
   } out_type;

   logic                 adv;
   logic [VLD_N-1:0]     vld_ff;
   logic [ALPHA_W-1:0]   alpha_ff;
   logic [DIV_BITS-1:0]  num;

   trk_type trk_a_in [DIV_BITS+1];
   trk_type trk_a_ff [DIV_BITS+1];
   div_type div_in   [DIV_BITS];
   div_type div_ff   [DIV_BITS];
   trk_type trk_v_ff [VEC_LAT];
   trk_type trk_r_ff [ROT_LAT];
   trk_type s_b0_in, s_b0_ff, s_b1_in, s_b1_ff, s_b2_in, s_b2_ff;
   trk_type s_b3_in, s_b3_ff, s_b4_in, s_b4_ff, s_c0_in, s_c0_ff;
   trk_type s_c1_in, s_c1_ff, s_c2_in, s_c2_ff, s_c3_in, s_c3_ff;
   trk_type s_c4_in, s_c4_ff;
   out_type out_in, out_ff;

   logic signed [31:0] rot0_c, rot0_s, rot2_c, rot2_s;
   logic        [31:0] vec_phi;

   function automatic logic signed [31:0] sat32(input logic signed [39:0] v);
      if (v > 40'sd2147483647)       return 32'sh7FFF_FFFF;
      else if (v < -40'sd2147483648) return 32'sh8000_0000;
      else                           return 32'(v);
   endfunction

   function automatic div_type div_step(input div_type prev, input logic nbit,
                                        input logic [31:0] den);
      logic [32:0] trial;
      div_type     nxt;
      trial = {prev.rem, nbit};
      if (trial >= {1'b0, den}) begin
         nxt.rem = 32'(trial - {1'b0, den});
         nxt.quo = {prev.quo[DIV_BITS-2:0], 1'b1};
      end else begin
         nxt.rem = trial[31:0];
         nxt.quo = {prev.quo[DIV_BITS-2:0], 1'b0};
      end
      return nxt;
   endfunction

   function automatic logic [31:0] mag32(input logic signed [31:0] v);
      return v[31] ? (32'd0 - 32'(v)) : 32'(v);
   endfunction

   // Whole pipeline moves when the response register is free or being taken
   assign adv          = !vld_ff[VLD_N-1] || rsp_ch.ready;
   assign req_ch.ready = adv && !reset;
   assign num          = {alpha_ff, 16'd0};

   // Capture the request beat
   always_comb begin
      trk_a_in[0]      = '0;
      trk_a_in[0].rx   = req_ch.ref_x;
      trk_a_in[0].ry   = req_ch.ref_y;
      trk_a_in[0].rz   = req_ch.ref_z;
      trk_a_in[0].dr   = req_ch.transverse_offset;
      trk_a_in[0].phi0 = req_ch.azimuth;
      trk_a_in[0].kap  = req_ch.curvature;
      trk_a_in[0].dz   = req_ch.longitudinal_offset;
      trk_a_in[0].tl   = req_ch.dip_tangent;
      trk_a_in[0].tx   = req_ch.target_x;
      trk_a_in[0].ty   = req_ch.target_y;
      trk_a_in[0].tz   = req_ch.target_z;
      for (int i = 1; i <= DIV_BITS; i++) trk_a_in[i] = trk_a_ff[i-1];
   end

   // Radius divider, one quotient bit per stage
   always_comb begin
      div_in[0] = div_step('0, num[DIV_BITS-1], mag32(trk_a_ff[0].kap));
      for (int i = 1; i < DIV_BITS; i++) begin
         div_in[i] = div_step(div_ff[i-1], num[DIV_BITS-1-i], mag32(trk_a_ff[i].kap));
      end
   end

   // Azimuth cosine and sine, timed to finish with the divider
   hpt_cordic_rot #(.STAGES(CORDIC_STAGES)) u_rot0 (
      .clock   (clock),
      .enable  (adv),
      .angle   (trk_a_ff[ROT_TAP].phi0),
      .cos_out (rot0_c),
      .sin_out (rot0_s)
   );

   // Signed, saturated radius
   always_comb begin
      logic [DIV_BITS-1:0] qm;
      qm      = div_ff[DIV_BITS-1].quo;
      s_b0_in = trk_a_ff[DIV_BITS];
      s_b0_in.c0   = rot0_c;
      s_b0_in.s0   = rot0_s;
      s_b0_in.rsat = 1'b0;
      if (trk_a_ff[DIV_BITS].kap == 0) begin
         s_b0_in.r    = 32'sh7FFF_FFFF;
         s_b0_in.rsat = 1'b1;
      end else if (!trk_a_ff[DIV_BITS].kap[31]) begin
         if (qm > DIV_BITS'(2147483647)) begin
            s_b0_in.r    = 32'sh7FFF_FFFF;
            s_b0_in.rsat = 1'b1;
         end else begin
            s_b0_in.r = $signed(qm[31:0]);
         end
      end else begin
         if (qm > DIV_BITS'(64'd2147483648)) begin
            s_b0_in.r    = 32'sh8000_0000;
            s_b0_in.rsat = 1'b1;
         end else begin
            s_b0_in.r = $signed(32'd0 - qm[31:0]);
         end
      end
   end

   // Offset radius and the products that need only the old frame
   always_comb begin
      s_b1_in     = s_b0_ff;
      s_b1_in.rdr = 33'(s_b0_ff.dr) + 33'(s_b0_ff.r);
      s_b1_in.mdc = 64'(s_b0_ff.dr) * 64'(s_b0_ff.c0);
      s_b1_in.mds = 64'(s_b0_ff.dr) * 64'(s_b0_ff.s0);
      s_b1_in.mrt = 64'(s_b0_ff.r) * 64'(s_b0_ff.tl);
   end

   // Center products, projection bases, slope clamp
   always_comb begin
      logic signed [63:0] mt;
      s_b2_in     = s_b1_ff;
      s_b2_in.mxc = 64'(s_b1_ff.rdr) * 64'(s_b1_ff.c0);
      s_b2_in.mys = 64'(s_b1_ff.rdr) * 64'(s_b1_ff.s0);
      s_b2_in.pxb = 36'(s_b1_ff.rx) + 36'(s_b1_ff.mdc >>> 30) - 36'(s_b1_ff.tx);
      s_b2_in.pyb = 36'(s_b1_ff.ry) + 36'(s_b1_ff.mds >>> 30) - 36'(s_b1_ff.ty);
      mt = s_b1_ff.mrt >>> 16;
      if (mt > LIM33)       s_b2_in.rt = 35'(LIM33);
      else if (mt < -LIM33) s_b2_in.rt = 35'(-LIM33);
      else                  s_b2_in.rt = 35'(mt);
      s_b2_in.zb = 34'(s_b1_ff.rz) + 34'(s_b1_ff.dz) - 34'(s_b1_ff.tz);
   end

   // Center relative to the new point
   always_comb begin
      s_b3_in    = s_b2_ff;
      s_b3_in.dx = 36'(s_b2_ff.rx) + 36'(s_b2_ff.mxc >>> 30) - 36'(s_b2_ff.tx);
      s_b3_in.dy = 36'(s_b2_ff.ry) + 36'(s_b2_ff.mys >>> 30) - 36'(s_b2_ff.ty);
   end

   // Flag a degenerate direction and orient the vector by the radius sign
   always_comb begin
      s_b4_in     = s_b3_ff;
      s_b4_in.deg = (s_b3_ff.r == 0) || (s_b3_ff.dx == 0 && s_b3_ff.dy == 0);
      if (s_b3_ff.r > 0) begin
         s_b4_in.dx = s_b3_ff.dx;
         s_b4_in.dy = s_b3_ff.dy;
      end else begin
         s_b4_in.dx = -s_b3_ff.dx;
         s_b4_in.dy = -s_b3_ff.dy;
      end
   end

   hpt_cordic_vec #(.STAGES(CORDIC_STAGES)) u_vec (
      .clock  (clock),
      .enable (adv),
      .x_in   (s_b4_ff.dx),
      .y_in   (s_b4_ff.dy),
      .phi    (vec_phi)
   );

   // New azimuth, zero when degenerate
   always_comb begin
      s_c0_in     = trk_v_ff[VEC_LAT-1];
      s_c0_in.phi = trk_v_ff[VEC_LAT-1].deg ? 32'd0 : vec_phi;
   end

   hpt_cordic_rot #(.STAGES(CORDIC_STAGES)) u_rot2 (
      .clock   (clock),
      .enable  (adv),
      .angle   (s_c0_ff.phi),
      .cos_out (rot2_c),
      .sin_out (rot2_s)
   );

   // New cosine and sine, wrapped azimuth change, direction deltas
   always_comb begin
      logic [31:0] d;
      s_c1_in    = trk_r_ff[ROT_LAT-1];
      s_c1_in.cs = trk_r_ff[ROT_LAT-1].deg ? 32'(ONE_Q30) : rot2_c;
      s_c1_in.sn = trk_r_ff[ROT_LAT-1].deg ? 32'sd0 : rot2_s;
      d = trk_r_ff[ROT_LAT-1].phi - trk_r_ff[ROT_LAT-1].phi0;
      // half a turn exactly counts as positive
      s_c1_in.phid = (d <= 32'h8000_0000) ? $signed({1'b0, d}) : $signed({1'b1, d});
      s_c1_in.dcs  = 33'(trk_r_ff[ROT_LAT-1].c0) - 33'(s_c1_in.cs);
      s_c1_in.dsn  = 33'(trk_r_ff[ROT_LAT-1].s0) - 33'(s_c1_in.sn);
   end

   // Radius times direction deltas, azimuth change to radians
   always_comb begin
      s_c2_in     = s_c1_ff;
      s_c2_in.mrc = 64'(s_c1_ff.r) * 64'(s_c1_ff.dcs);
      s_c2_in.mrs = 64'(s_c1_ff.r) * 64'(s_c1_ff.dsn);
      s_c2_in.mph = 64'(s_c1_ff.phid) * TWO_PI_Q28;
   end

   // Displacement, clamped; radians in Q4.28
   always_comb begin
      logic signed [35:0] pxr, pyr;
      s_c3_in = s_c2_ff;
      pxr = s_c2_ff.pxb + 36'(s_c2_ff.mrc >>> 30);
      pyr = s_c2_ff.pyb + 36'(s_c2_ff.mrs >>> 30);
      if (pxr > LIM33 - 1)         s_c3_in.px = 36'(LIM33 - 1);
      else if (pxr < -(LIM33 - 1)) s_c3_in.px = 36'(-(LIM33 - 1));
      else                         s_c3_in.px = pxr;
      if (pyr > LIM33 - 1)         s_c3_in.py = 36'(LIM33 - 1);
      else if (pyr < -(LIM33 - 1)) s_c3_in.py = 36'(-(LIM33 - 1));
      else                         s_c3_in.py = pyr;
      s_c3_in.ph = 32'(s_c2_ff.mph >>> 32);
   end

   // Projection and dip products
   always_comb begin
      s_c4_in     = s_c3_ff;
      s_c4_in.mpc = 64'(s_c3_ff.px) * 64'(s_c3_ff.cs);
      s_c4_in.mps = 64'(s_c3_ff.py) * 64'(s_c3_ff.sn);
      s_c4_in.mrp = 64'(s_c3_ff.rt) * 64'(s_c3_ff.ph);
   end

   // Final sums and saturation
   always_comb begin
      out_in.drp  = sat32(40'(s_c4_ff.mpc >>> 30) + 40'(s_c4_ff.mps >>> 30));
      out_in.dzp  = sat32(40'(s_c4_ff.zb) - 40'(s_c4_ff.mrp >>> 28));
      out_in.phi  = s_c4_ff.phi;
      out_in.rsat = s_c4_ff.rsat;
      out_in.deg  = s_c4_ff.deg;
   end

   // Valid chain and curvature constant
   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff   <= '0;
         alpha_ff <= ALPHA_RESET;
      end else begin
         if (adv) vld_ff <= {vld_ff[VLD_N-2:0], req_ch.valid};
         if (csr_wr_en) alpha_ff <= csr_wr_data;
      end
   end

   // Payload stages, all held on a stall
   always_ff @(posedge clock) begin
      if (adv) begin
         for (int i = 0; i <= DIV_BITS; i++) trk_a_ff[i] <= trk_a_in[i];
         for (int i = 0; i < DIV_BITS; i++)  div_ff[i]   <= div_in[i];
         s_b0_ff <= s_b0_in;
         s_b1_ff <= s_b1_in;
         s_b2_ff <= s_b2_in;
         s_b3_ff <= s_b3_in;
         s_b4_ff <= s_b4_in;
         trk_v_ff[0] <= s_b4_ff;
         for (int i = 1; i < VEC_LAT; i++) trk_v_ff[i] <= trk_v_ff[i-1];
         s_c0_ff <= s_c0_in;
         trk_r_ff[0] <= s_c0_ff;
         for (int i = 1; i < ROT_LAT; i++) trk_r_ff[i] <= trk_r_ff[i-1];
         s_c1_ff <= s_c1_in;
         s_c2_ff <= s_c2_in;
         s_c3_ff <= s_c3_in;
         s_c4_ff <= s_c4_in;
         out_ff  <= out_in;
      end
   end

   assign rsp_ch.valid                   = vld_ff[VLD_N-1];
   assign rsp_ch.out_transverse_offset   = out_ff.drp;
   assign rsp_ch.out_azimuth             = out_ff.phi;
   assign rsp_ch.out_longitudinal_offset = out_ff.dzp;
   assign rsp_ch.radius_saturated        = out_ff.rsat;
   assign rsp_ch.direction_degenerate    = out_ff.deg;

endmodule

FILE: tb/tb_helix_pivot_transform_unit.sv
// Self-checking bench for the helix pivot transform: random and corner helices,
// bit-exact prediction in a scoreboard class. Depends on hpt_pkg, the channel interfaces and the unit.
module tb_helix_pivot_transform_unit import hpt_pkg::*; ();

   localparam int STAGES   = 24;
   localparam int LATENCY  = 2*STAGES + 68;
   localparam int WD_LIMIT = 20000;

   typedef struct {
      logic signed [31:0] ref_x, ref_y, ref_z, tof, curv, lof, dip, tgt_x, tgt_y, tgt_z;
      logic        [31:0] azim;
   } helix_type;

   typedef struct {
      logic signed [31:0] tof;
      logic        [31:0] azim;
      logic signed [31:0] lof;
      logic               rsat;
      logic               deg;
   } pivot_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic csr_wr_en = 1'b0;
   logic [ALPHA_W-1:0] csr_wr_data = '0;
   int   n_err = 0;
   int   idle_cnt = 0;
   bit   no_idle = 1'b0;
   bit   hold_rsp = 1'b0;
   bit   timed_out = 1'b0;

   hpt_req_if req_ch();
   hpt_rsp_if rsp_ch();

   helix_pivot_transform_unit #(.CORDIC_STAGES(STAGES)) dut (
      .clock(clock), .reset(reset), .req_ch(req_ch.sink), .rsp_ch(rsp_ch.source),
      .csr_wr_en(csr_wr_en), .csr_wr_data(csr_wr_data)
   );

   always #1 clock = ~clock;

   task automatic report(input string what, input longint got, input longint want);
      $display("mismatch %s: got %0d want %0d", what, got, want);
      n_err++;
   endtask

   class pivot_board_type;
      longint alpha = longint'(ALPHA_RESET);
      pivot_type pending[$];

      function longint floor_shr(longint v, int s);
         return v >>> s;
      endfunction

      function longint clip(longint v, longint lo, longint hi);
         return v < lo ? lo : (v > hi ? hi : v);
      endfunction

      function void rotate(logic [31:0] a, output longint c, output longint s);
         logic [31:0] add_q, t;
         bit flip;
         longint x, y, z, dx, dy;
         add_q = a + 32'h4000_0000;
         flip = add_q[31];
         t = flip ? a + 32'h8000_0000 : a;
         z = longint'($signed(t));
         x = GAIN_Q30;
         y = 0;
         for (int i = 0; i < STAGES; i++) begin
            dx = floor_shr(y, i);
            dy = floor_shr(x, i);
            if (z >= 0) begin
               x -= dx; y += dy; z -= longint'(atan_turn(i[4:0]));
            end else begin
               x += dx; y -= dy; z += longint'(atan_turn(i[4:0]));
            end
         end
         if (flip) begin
            x = -x; y = -y;
         end
         c = clip(x, -ONE_Q30, ONE_Q30);
         s = clip(y, -ONE_Q30, ONE_Q30);
      endfunction

      function logic [31:0] vector_angle(longint x, longint y);
         logic [31:0] z;
         longint dx, dy;
         z = '0;
         if (x < 0) begin
            x = -x; y = -y; z = 32'h8000_0000;
         end
         for (int n = 0; n < 64 && x < (64'sd1 <<< 40) && y < (64'sd1 <<< 40)
              && y > -(64'sd1 <<< 40); n++) begin
            x *= 2; y *= 2;
         end
         for (int i = 0; i < STAGES; i++) begin
            dx = floor_shr(y, i);
            dy = floor_shr(x, i);
            if (y < 0) begin
               x -= dx; y += dy; z = z - atan_turn(i[4:0]);
            end else begin
               x += dx; y -= dy; z = z + atan_turn(i[4:0]);
            end
         end
         return z;
      endfunction

      // Predict one pivot result and queue it
      function void note_helix(helix_type h);
         longint r, q, c0, s0, cs, sn, xc, yc, dx, dy, phid, px, py, drp, rt, ph, dzp;
         logic [31:0] phi, d;
         pivot_type p;
         p.rsat = 1'b0;
         p.deg = 1'b0;
         if (h.curv == 0) begin
            r = 64'sd2147483647; p.rsat = 1'b1;
         end else begin
            q = (alpha * 65536) / longint'(h.curv);
            r = clip(q, -64'sd2147483648, 64'sd2147483647);
            p.rsat = (r != q);
         end
         rotate(h.azim, c0, s0);
         xc = h.ref_x + floor_shr((h.tof + r) * c0, 30);
         yc = h.ref_y + floor_shr((h.tof + r) * s0, 30);
         dx = xc - h.tgt_x;
         dy = yc - h.tgt_y;
         if (r != 0 && (dx != 0 || dy != 0)) begin
            phi = (r > 0) ? vector_angle(dx, dy) : vector_angle(-dx, -dy);
            rotate(phi, cs, sn);
         end else begin
            phi = '0; cs = ONE_Q30; sn = 0; p.deg = 1'b1;
         end
         d = phi - h.azim;
         phid = (d <= 32'h8000_0000) ? longint'(d) : longint'(d) - 64'sd4294967296;
         px = h.ref_x + floor_shr(h.tof * c0, 30) + floor_shr(r * (c0 - cs), 30) - h.tgt_x;
         py = h.ref_y + floor_shr(h.tof * s0, 30) + floor_shr(r * (s0 - sn), 30) - h.tgt_y;
         px = clip(px, -(LIM33 - 1), LIM33 - 1);
         py = clip(py, -(LIM33 - 1), LIM33 - 1);
         drp = floor_shr(px * cs, 30) + floor_shr(py * sn, 30);
         rt = clip(floor_shr(r * h.dip, 16), -LIM33, LIM33);
         ph = floor_shr(phid * TWO_PI_Q28, 32);
         dzp = h.ref_z + h.lof - floor_shr(rt * ph, 28) - h.tgt_z;
         p.tof = 32'(clip(drp, -64'sd2147483648, 64'sd2147483647));
         p.azim = phi;
         p.lof = 32'(clip(dzp, -64'sd2147483648, 64'sd2147483647));
         pending.push_back(p);
      endfunction

      // Compare one result beat with the oldest prediction
      task check_pivot(pivot_type g);
         pivot_type w;
         if (pending.size() == 0) begin
            report("unexpected beat", 0, 0);
            return;
         end
         w = pending.pop_front();
         if (g.tof !== w.tof) report("out_transverse_offset", g.tof, w.tof);
         if (g.azim !== w.azim) report("out_azimuth", g.azim, w.azim);
         if (g.lof !== w.lof) report("out_longitudinal_offset", g.lof, w.lof);
         if (g.rsat !== w.rsat) report("radius_saturated", g.rsat, w.rsat);
         if (g.deg !== w.deg) report("direction_degenerate", g.deg, w.deg);
      endtask
   endclass

   pivot_board_type board = new();

   // Sample both channels at the edge; drives change only after it
   always @(posedge clock) begin
      pivot_type g;
      helix_type h;
      if (!reset && req_ch.valid && req_ch.ready) begin
         h.ref_x = req_ch.ref_x; h.ref_y = req_ch.ref_y; h.ref_z = req_ch.ref_z;
         h.tof = req_ch.transverse_offset; h.azim = req_ch.azimuth;
         h.curv = req_ch.curvature; h.lof = req_ch.longitudinal_offset;
         h.dip = req_ch.dip_tangent; h.tgt_x = req_ch.target_x;
         h.tgt_y = req_ch.target_y; h.tgt_z = req_ch.target_z;
         board.note_helix(h);
      end
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         g.tof = rsp_ch.out_transverse_offset; g.azim = rsp_ch.out_azimuth;
         g.lof = rsp_ch.out_longitudinal_offset; g.rsat = rsp_ch.radius_saturated;
         g.deg = rsp_ch.direction_degenerate;
         board.check_pivot(g);
      end
   end

   // Watchdog: count cycles with no beat on either side
   always @(posedge clock) begin
      if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
         idle_cnt <= 0;
      else if (!reset && (req_ch.valid || board.pending.size() != 0))
         idle_cnt <= idle_cnt + 1;
      if (idle_cnt >= WD_LIMIT && !timed_out) begin
         timed_out = 1'b1;
         $display("TEST FAILED");
         $finish;
      end
   end

   // Receiver: random stall bursts, plus one long hold-off on request
   initial begin
      int n;
      rsp_ch.ready <= 1'b0;
      @(posedge clock);
      while (1) begin
         if (hold_rsp) begin
            rsp_ch.ready <= 1'b0;
            repeat (400) @(posedge clock);
            hold_rsp = 1'b0;
         end else if (!no_idle && $urandom_range(0, 5) == 0) begin
            rsp_ch.ready <= 1'b0;
            n = $urandom_range(1, 4);
            repeat (n) @(posedge clock);
         end else begin
            rsp_ch.ready <= 1'b1;
            @(posedge clock);
         end
      end
   end

   function automatic logic [31:0] pick32();
      case ($urandom_range(0, 9))
         0: return 32'h8000_0000;
         1: return 32'h7FFF_FFFF;
         2: return 32'h0;
         3: return 32'hFFFF_FFFF;
         4, 5: return $urandom;
         default: return 32'($signed($urandom_range(0, 2000 << 16)) - (1000 << 16));
      endcase
   endfunction

   function automatic helix_type rand_helix();
      helix_type h;
      h.ref_x = pick32(); h.ref_y = pick32(); h.ref_z = pick32();
      h.tof = pick32(); h.azim = $urandom; h.lof = pick32();
      h.tgt_x = pick32(); h.tgt_y = pick32(); h.tgt_z = pick32();
      h.dip = ($urandom_range(0, 3) == 0) ? pick32()
            : 32'($signed($urandom_range(0, 8 << 16)) - (4 << 16));
      case ($urandom_range(0, 5))
         0: h.curv = pick32();
         1: h.curv = 32'($signed($urandom_range(0, 8)) - 4);
         default: h.curv = 32'($signed($urandom_range(1 << 12, 4 << 16)))
                          * ($urandom_range(0, 1) ? 1 : -1);
      endcase
      // Sometimes put the target on the reference point
      if ($urandom_range(0, 15) == 0) begin
         h.tgt_x = h.ref_x; h.tgt_y = h.ref_y;
      end
      return h;
   endfunction

   // Hold one beat until accepted, with random gaps beforehand
   task automatic send_helix(input helix_type h);
      int n;
      if (!no_idle && $urandom_range(0, 5) == 0) begin
         req_ch.valid <= 1'b0;
         n = $urandom_range(1, 4);
         repeat (n) @(posedge clock);
      end
      req_ch.valid <= 1'b1;
      req_ch.ref_x <= h.ref_x; req_ch.ref_y <= h.ref_y; req_ch.ref_z <= h.ref_z;
      req_ch.transverse_offset <= h.tof; req_ch.azimuth <= h.azim;
      req_ch.curvature <= h.curv; req_ch.longitudinal_offset <= h.lof;
      req_ch.dip_tangent <= h.dip; req_ch.target_x <= h.tgt_x;
      req_ch.target_y <= h.tgt_y; req_ch.target_z <= h.tgt_z;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
   endtask

   task automatic drain();
      req_ch.valid <= 1'b0;
      while (board.pending.size() != 0) @(posedge clock);
      repeat (LATENCY + 10) @(posedge clock);
   endtask

   task automatic write_alpha(input logic [ALPHA_W-1:0] a);
      csr_wr_en <= 1'b1;
      csr_wr_data <= a;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      board.alpha = longint'(a);
      @(posedge clock);
   endtask

   initial begin
      helix_type h;
      logic [ALPHA_W-1:0] settings[5];
      settings = '{31'd21860456, 31'h7FFF_FFFF, 31'd1, 31'd0, 31'd655360};
      req_ch.valid <= 1'b0;
      {req_ch.ref_x, req_ch.ref_y, req_ch.ref_z, req_ch.transverse_offset,
       req_ch.azimuth, req_ch.curvature, req_ch.longitudinal_offset} <= '0;
      {req_ch.dip_tangent, req_ch.target_x, req_ch.target_y, req_ch.target_z} <= '0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed corners at reset alpha
      h = '{default: 0};
      send_helix(h);                                // zero curvature
      h.curv = 32'sd1; send_helix(h);              // radius overflow
      h.curv = -32'sd1; send_helix(h);
      h.curv = 32'sh8000_0000; h.azim = 32'h8000_0000; send_helix(h);
      h.curv = 32'sh7FFF_FFFF; h.azim = 32'hFFFF_FFFF; send_helix(h);
      h.curv = 32'sd65536; h.azim = 32'h4000_0000; send_helix(h);
      h.ref_x = 32'sh7FFF_FFFF; h.ref_y = 32'sh8000_0000; h.tgt_x = 32'sh8000_0000;
      h.tgt_y = 32'sh7FFF_FFFF; h.dip = 32'sh7FFF_FFFF; h.lof = 32'sh7FFF_FFFF;
      h.ref_z = 32'sh7FFF_FFFF; h.tgt_z = 32'sh8000_0000; h.tof = 32'sh8000_0000;
      send_helix(h);
      h.dip = 32'sh8000_0000; h.tof = 32'sh7FFF_FFFF; h.curv = -32'sd65536;
      send_helix(h);
      // Target on the center: alpha/curv = 1, radius 2^16 -> pick center exactly
      h = '{default: 0};
      h.curv = 32'sd21860456; h.tgt_x = 32'sd65536; send_helix(h);
      h.azim = 32'h8000_0000; h.tgt_x = -32'sd65536; send_helix(h);
      for (int i = 0; i < 10; i++) send_helix(rand_helix());
      drain();

      // Long receiver hold-off while requests keep flowing
      hold_rsp = 1'b1;
      for (int i = 0; i < 250; i++) send_helix(rand_helix());

      // Random phases across alpha settings, extremes included
      for (int p = 0; p < 5; p++) begin
         drain();
         write_alpha(settings[p]);
         if (p == 4) no_idle = 1'b1;
         for (int i = 0; i < 130; i++) send_helix(rand_helix());
      end
      drain();

      if (n_err == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end
endmodule

FILE: sim.f
sv/hpt_pkg.sv
sv/hpt_req_if.sv
sv/hpt_rsp_if.sv
sv/hpt_cordic_rot.sv
sv/hpt_cordic_vec.sv
sv/helix_pivot_transform_unit.sv
tb/tb_helix_pivot_transform_unit.sv
